// ===== rtl/ted_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ted_pkg
// Shared types and constants of the tree edit distance block.
// ----------------------------------------------------------------------------
package ted_pkg;

    localparam int LABEL_W = 16;   // width of a label on the request channel
    localparam int LEAF_W  = 7;    // width of a leftmost-leaf index
    localparam int DIST_W  = 8;    // width of a reported distance

    typedef enum logic [1:0] {
        ACT_LOAD_FIRST  = 2'd0,
        ACT_LOAD_SECOND = 2'd1,
        ACT_COMPUTE     = 2'd2,
        ACT_NOP         = 2'd3
    } action_t;

endpackage
`default_nettype wire

// ===== rtl/ted_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ted_if
// Valid/ready channels: node and compute requests in, distances out.
// ----------------------------------------------------------------------------
interface ted_req_if;
    import ted_pkg::*;

    logic                valid;
    logic                ready;
    action_t             action;
    logic [LABEL_W-1:0]  label;
    logic [LEAF_W-1:0]   leftmost_leaf;

    modport source (output valid, action, label, leftmost_leaf, input ready);
    modport sink   (input valid, action, label, leftmost_leaf, output ready);
endinterface

interface ted_rsp_if;
    import ted_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  distance;
    logic               overflowed;

    modport source (output valid, distance, overflowed, input ready);
    modport sink   (input valid, distance, overflowed, output ready);
endinterface
`default_nettype wire

// ===== rtl/ted_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ted_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ted_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tree_edit_distance.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tree_edit_distance
// Zhang-Shasha tree edit distance, unit delete/insert/rename costs, computed
// by a small sequencer around one shared add/min unit and block RAMs.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  -------   ---  -------------  ------------------------------------------
//  request   in   valid/ready    action, label, leftmost_leaf
//  reply     out  valid/ready    distance, overflowed
//
//  Loads are taken while the sequencer is idle and stream at one request per cycle.
//  A compute clears the n1*n2 entries of the subtree table, tests each keyroot,
//  then fills each forest row and forest cell, all bound by the single read
//  port of the forest table; ready stays low until the result has been moved
//  to the reply register.
//  Reset clears node counts, the overflow flag, the reply valid flag and the sequencer only.
//  A stalled reply holds its register; loads are still taken meanwhile.
//
module tree_edit_distance #(
    parameter int MAX_NODES  = 64,
    parameter int LABEL_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ted_req_if.sink    request,
    ted_rsp_if.source  reply
);
    import ted_pkg::*;

    localparam int NW   = $clog2(MAX_NODES);          // node address bits
    localparam int CW   = $clog2(MAX_NODES + 1);      // node index 1..N bits
    localparam int DW   = $clog2(2 * MAX_NODES + 1);  // forest distance bits
    localparam int LW   = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
    localparam int LCMP = (CW > LEAF_W) ? CW : LEAF_W;
    localparam int RW   = (DW > DIST_W) ? DW : DIST_W;
    localparam int FD_DEPTH = 1 << (2 * CW);
    localparam int SD_DEPTH = 1 << (2 * NW);
    localparam logic [RW-1:0] DIST_MAX = RW'((1 << DIST_W) - 1);
    localparam logic [CW-1:0] NODES_CAP = CW'(MAX_NODES);

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_CLR  = 16'h0002,
        S_I0   = 16'h0004,
        S_I1   = 16'h0008,
        S_I2   = 16'h0010,
        S_J0   = 16'h0020,
        S_J1   = 16'h0040,
        S_J2   = 16'h0080,
        S_R0   = 16'h0100,
        S_R1   = 16'h0200,
        S_C0   = 16'h0400,
        S_C1   = 16'h0800,
        S_C2   = 16'h1000,
        S_FIN0 = 16'h2000,
        S_FIN1 = 16'h4000,
        S_DONE = 16'h8000
    } state_t;

    // clamp a bad leftmost leaf to the node's own index
    function automatic logic [CW-1:0] fix_leaf(input logic [LEAF_W-1:0] v,
                                               input logic [CW-1:0] k);
        logic [LCMP-1:0] ve;
        logic [LCMP-1:0] ke;
        ve = LCMP'(v);
        ke = LCMP'(k);
        if (ve == '0 || ve > ke)
        begin
            return k;
        end
        return CW'(ve);
    endfunction

    // ---- registers ----
    state_t            state_reg,    state_next;
    logic [CW-1:0]     count1_reg,   count1_next;
    logic [CW-1:0]     count2_reg,   count2_next;
    logic              ovf_reg,      ovf_next;
    logic [CW-1:0]     i_reg,        i_next;
    logic [CW-1:0]     j_reg,        j_next;
    logic [CW-1:0]     li_reg,       li_next;
    logic [CW-1:0]     lj_reg,       lj_next;
    logic [CW-1:0]     i1_reg,       i1_next;
    logic [CW-1:0]     j1_reg,       j1_next;
    logic [CW-1:0]     x_reg,        x_next;
    logic [CW-1:0]     y_reg,        y_next;
    logic [CW-1:0]     lmi1_reg,     lmi1_next;
    logic [LW-1:0]     labi1_reg,    labi1_next;
    logic [DW-1:0]     ins_reg,      ins_next;
    logic [DW-1:0]     del_reg,      del_next;
    logic              match_reg,    match_next;
    logic              cost_reg,     cost_next;
    logic [DW-1:0]     sdv_reg,      sdv_next;
    logic [CW-1:0]     pa_reg,       pa_next;
    logic [CW-1:0]     pb_reg,       pb_next;
    logic [NW-1:0]     ca_reg,       ca_next;
    logic [NW-1:0]     cb_reg,       cb_next;
    logic [DW-1:0]     res_reg,      res_next;
    logic              ovalid_reg,   ovalid_next;
    logic [DIST_W-1:0] odist_reg,    odist_next;
    logic              oovf_reg,     oovf_next;

    // ---- RAM ports ----
    logic              lab1_we, lab2_we, lm1_we, lm2_we, last1_we, last2_we;
    logic              lab1_re, lab2_re, lm1_re, lm2_re, last1_re, last2_re;
    logic [NW-1:0]     lab1_ra, lab2_ra, lm1_ra, lm2_ra, last1_ra, last2_ra;
    logic [NW-1:0]     last1_wa, last2_wa;
    logic [LW-1:0]     lab1_q, lab2_q;
    logic [CW-1:0]     lm1_q, lm2_q;
    logic [NW-1:0]     last1_q, last2_q;
    logic [CW-1:0]     lmv1, lmv2;
    logic              fd_we, fd_re, sd_we, sd_re;
    logic [2*CW-1:0]   fd_wa, fd_ra;
    logic [2*NW-1:0]   sd_wa, sd_ra;
    logic [DW-1:0]     fd_wd, sd_wd, fd_q, sd_q;

    logic              req_fire;
    logic [DW:0]       del1, ins1, third, best;
    logic [DW-1:0]     fval;
    logic [RW-1:0]     res_ext;

    assign req_fire = request.valid && request.ready;
    assign lmv1 = fix_leaf(request.leftmost_leaf, count1_reg + 1'b1);
    assign lmv2 = fix_leaf(request.leftmost_leaf, count2_reg + 1'b1);

    // node stores: written by loads at the fill count
    assign lab1_we  = req_fire && request.action == ACT_LOAD_FIRST && count1_reg < NODES_CAP;
    assign lm1_we   = lab1_we;
    assign last1_we = lab1_we;
    assign lab2_we  = req_fire && request.action == ACT_LOAD_SECOND && count2_reg < NODES_CAP;
    assign lm2_we   = lab2_we;
    assign last2_we = lab2_we;
    // last node seen per leftmost leaf: a node is a keyroot if it is still that node
    assign last1_wa = NW'(lmv1 - 1'b1);
    assign last2_wa = NW'(lmv2 - 1'b1);

    // shared add/min unit for a forest cell
    assign fval  = (pa_reg == '0) ? DW'(pb_reg) : ((pb_reg == '0) ? DW'(pa_reg) : fd_q);
    assign del1  = {1'b0, del_reg} + 1'b1;
    assign ins1  = {1'b0, ins_reg} + 1'b1;
    assign third = match_reg ? ({1'b0, fval} + cost_reg) : ({1'b0, fval} + {1'b0, sdv_reg});
    always_comb
    begin
        best = (del1 < ins1) ? del1 : ins1;
        if (third < best)
        begin
            best = third;
        end
    end

    assign res_ext = RW'(res_reg);

    always_comb
    begin
        logic [CW-1:0] ox;
        logic [CW-1:0] oy;
        logic [CW-1:0] ra;
        logic [CW-1:0] rb;
        logic          adv_j;
        logic          adv_i;

        state_next  = state_reg;
        count1_next = count1_reg;
        count2_next = count2_reg;
        ovf_next    = ovf_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        li_next     = li_reg;
        lj_next     = lj_reg;
        i1_next     = i1_reg;
        j1_next     = j1_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        lmi1_next   = lmi1_reg;
        labi1_next  = labi1_reg;
        ins_next    = ins_reg;
        del_next    = del_reg;
        match_next  = match_reg;
        cost_next   = cost_reg;
        sdv_next    = sdv_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        odist_next  = odist_reg;
        oovf_next   = oovf_reg;

        lab1_re = 1'b0; lab2_re = 1'b0; lm1_re = 1'b0; lm2_re = 1'b0;
        last1_re = 1'b0; last2_re = 1'b0;
        lab1_ra = NW'(i1_reg - 1'b1);
        lm1_ra  = NW'(i_reg - 1'b1);
        lab2_ra = NW'(j1_reg - 1'b1);
        lm2_ra  = NW'(j_reg - 1'b1);
        last1_ra = NW'(lm1_q - 1'b1);
        last2_ra = NW'(lm2_q - 1'b1);
        fd_we = 1'b0; fd_re = 1'b0; sd_we = 1'b0; sd_re = 1'b0;
        fd_wa = {x_reg, y_reg};
        fd_ra = {CW'(x_reg - 1'b1), y_reg};
        fd_wd = DW'(best);
        sd_wa = {NW'(i1_reg - 1'b1), NW'(j1_reg - 1'b1)};
        sd_ra = sd_wa;
        sd_wd = DW'(best);
        ox = '0; oy = '0; ra = '0; rb = '0;
        adv_j = 1'b0;
        adv_i = 1'b0;

        // drop the reply once taken
        if (ovalid_reg && reply.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (request.action)
                        ACT_LOAD_FIRST:
                        begin
                            if (count1_reg < NODES_CAP)
                                count1_next = count1_reg + 1'b1;
                            else
                                ovf_next = 1'b1;
                        end
                        ACT_LOAD_SECOND:
                        begin
                            if (count2_reg < NODES_CAP)
                                count2_next = count2_reg + 1'b1;
                            else
                                ovf_next = 1'b1;
                        end
                        ACT_COMPUTE:
                        begin
                            if (count1_reg == '0 || count2_reg == '0)
                            begin
                                res_next   = (count1_reg == '0) ? DW'(count2_reg)
                                                                : DW'(count1_reg);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ca_next    = '0;
                                cb_next    = '0;
                                state_next = S_CLR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                sd_we = 1'b1;
                sd_wa = {ca_reg, cb_reg};
                sd_wd = '0;
                if (cb_reg == NW'(count2_reg - 1'b1))
                begin
                    cb_next = '0;
                    if (ca_reg == NW'(count1_reg - 1'b1))
                    begin
                        i_next     = CW'(1);
                        state_next = S_I0;
                    end
                    else
                    begin
                        ca_next = ca_reg + 1'b1;
                    end
                end
                else
                begin
                    cb_next = cb_reg + 1'b1;
                end
            end
            S_I0:
            begin
                lm1_re     = 1'b1;
                state_next = S_I1;
            end
            S_I1:
            begin
                li_next    = lm1_q;
                last1_re   = 1'b1;
                state_next = S_I2;
            end
            S_I2:
            begin
                if (last1_q == NW'(i_reg - 1'b1))
                begin
                    j_next     = CW'(1);
                    state_next = S_J0;
                end
                else
                begin
                    adv_i = 1'b1;
                end
            end
            S_J0:
            begin
                lm2_re     = 1'b1;
                state_next = S_J1;
            end
            S_J1:
            begin
                lj_next    = lm2_q;
                last2_re   = 1'b1;
                state_next = S_J2;
            end
            S_J2:
            begin
                if (last2_q == NW'(j_reg - 1'b1))
                begin
                    i1_next    = li_reg;
                    x_next     = CW'(1);
                    state_next = S_R0;
                end
                else
                begin
                    adv_j = 1'b1;
                end
            end
            S_R0:
            begin
                lm1_re     = 1'b1;
                lm1_ra     = NW'(i1_reg - 1'b1);
                lab1_re    = 1'b1;
                state_next = S_R1;
            end
            S_R1:
            begin
                lmi1_next  = lm1_q;
                labi1_next = lab1_q;
                j1_next    = lj_reg;
                y_next     = CW'(1);
                ins_next   = DW'(x_reg);
                state_next = S_C0;
            end
            S_C0:
            begin
                lm2_re     = 1'b1;
                lm2_ra     = NW'(j1_reg - 1'b1);
                lab2_re    = 1'b1;
                fd_re      = 1'b1;
                sd_re      = 1'b1;
                state_next = S_C1;
            end
            S_C1:
            begin
                del_next   = (x_reg == CW'(1)) ? DW'(y_reg) : fd_q;
                match_next = (lmi1_reg == li_reg) && (lm2_q == lj_reg);
                cost_next  = (labi1_reg != lab2_q);
                sdv_next   = sd_q;
                ox = (lmi1_reg > li_reg) ? (lmi1_reg - li_reg) : '0;
                oy = (lm2_q > lj_reg) ? (lm2_q - lj_reg) : '0;
                if ((lmi1_reg == li_reg) && (lm2_q == lj_reg))
                begin
                    ra = x_reg - 1'b1;
                    rb = y_reg - 1'b1;
                end
                else
                begin
                    ra = ox;
                    rb = oy;
                end
                pa_next    = ra;
                pb_next    = rb;
                fd_re      = 1'b1;
                fd_ra      = {ra, rb};
                state_next = S_C2;
            end
            S_C2:
            begin
                fd_we    = 1'b1;
                sd_we    = match_reg;
                ins_next = DW'(best);
                if (j1_reg == j_reg)
                begin
                    if (i1_reg == i_reg)
                    begin
                        adv_j = 1'b1;
                    end
                    else
                    begin
                        i1_next    = i1_reg + 1'b1;
                        x_next     = x_reg + 1'b1;
                        state_next = S_R0;
                    end
                end
                else
                begin
                    j1_next    = j1_reg + 1'b1;
                    y_next     = y_reg + 1'b1;
                    state_next = S_C0;
                end
            end
            S_FIN0:
            begin
                sd_re      = 1'b1;
                sd_ra      = {NW'(count1_reg - 1'b1), NW'(count2_reg - 1'b1)};
                state_next = S_FIN1;
            end
            S_FIN1:
            begin
                res_next   = sd_q;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || reply.ready)
                begin
                    ovalid_next = 1'b1;
                    odist_next  = (res_ext > DIST_MAX) ? DIST_W'(DIST_MAX)
                                                       : DIST_W'(res_ext);
                    oovf_next   = ovf_reg;
                    count1_next = '0;
                    count2_next = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance the second keyroot, then the first
        if (adv_j)
        begin
            if (j_reg == count2_reg)
            begin
                adv_i = 1'b1;
            end
            else
            begin
                j_next     = j_reg + 1'b1;
                state_next = S_J0;
            end
        end
        if (adv_i)
        begin
            if (i_reg == count1_reg)
            begin
                state_next = S_FIN0;
            end
            else
            begin
                i_next     = i_reg + 1'b1;
                state_next = S_I0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count1_reg <= '0;
            count2_reg <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count1_reg <= count1_next;
            count2_reg <= count2_next;
            ovf_reg    <= ovf_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        li_reg    <= li_next;
        lj_reg    <= lj_next;
        i1_reg    <= i1_next;
        j1_reg    <= j1_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        lmi1_reg  <= lmi1_next;
        labi1_reg <= labi1_next;
        ins_reg   <= ins_next;
        del_reg   <= del_next;
        match_reg <= match_next;
        cost_reg  <= cost_next;
        sdv_reg   <= sdv_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        ca_reg    <= ca_next;
        cb_reg    <= cb_next;
        res_reg   <= res_next;
        odist_reg <= odist_next;
        oovf_reg  <= oovf_next;
    end

    assign request.ready    = (state_reg == S_IDLE);
    assign reply.valid      = ovalid_reg;
    assign reply.distance   = odist_reg;
    assign reply.overflowed = oovf_reg;

    // ---- memories ----
    ted_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_lab1 (
        .clk(clk), .we(lab1_we), .waddr(NW'(count1_reg)),
        .wdata(request.label[LW-1:0]),
        .re(lab1_re), .raddr(lab1_ra), .rdata(lab1_q));
    ted_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_lm1 (
        .clk(clk), .we(lm1_we), .waddr(NW'(count1_reg)), .wdata(lmv1),
        .re(lm1_re), .raddr(lm1_ra), .rdata(lm1_q));
    ted_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_last1 (
        .clk(clk), .we(last1_we), .waddr(last1_wa), .wdata(NW'(count1_reg)),
        .re(last1_re), .raddr(last1_ra), .rdata(last1_q));
    ted_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_lab2 (
        .clk(clk), .we(lab2_we), .waddr(NW'(count2_reg)),
        .wdata(request.label[LW-1:0]),
        .re(lab2_re), .raddr(lab2_ra), .rdata(lab2_q));
    ted_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_lm2 (
        .clk(clk), .we(lm2_we), .waddr(NW'(count2_reg)), .wdata(lmv2),
        .re(lm2_re), .raddr(lm2_ra), .rdata(lm2_q));
    ted_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_last2 (
        .clk(clk), .we(last2_we), .waddr(last2_wa), .wdata(NW'(count2_reg)),
        .re(last2_re), .raddr(last2_ra), .rdata(last2_q));
    ted_ram #(.WIDTH(DW), .DEPTH(FD_DEPTH)) u_forest (
        .clk(clk), .we(fd_we), .waddr(fd_wa), .wdata(fd_wd),
        .re(fd_re), .raddr(fd_ra), .rdata(fd_q));
    ted_ram #(.WIDTH(DW), .DEPTH(SD_DEPTH)) u_subtree (
        .clk(clk), .we(sd_we), .waddr(sd_wa), .wdata(sd_wd),
        .re(sd_re), .raddr(sd_ra), .rdata(sd_q));
endmodule
`default_nettype wire

// ===== rtl/ted_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ted_checker
// Port-level checks of the tree edit distance block, bound to its top level.
// ----------------------------------------------------------------------------
module ted_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire ted_pkg::action_t  in_action,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [7:0]        distance,
    input wire logic              overflowed
);
    import ted_pkg::*;

    // a compute request holds off further requests
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_action == ACT_COMPUTE) |=> !in_ready)
        else $error("request taken right after a compute");

    // a new result only appears after a busy cycle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a compute in flight");

    // a stalled result holds
    a_reply_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(distance)
                                       && $stable(overflowed)))
        else $error("stalled result changed");
endmodule

bind tree_edit_distance ted_checker u_ted_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(request.valid),
    .in_ready(request.ready),
    .in_action(request.action),
    .out_valid(reply.valid),
    .out_ready(reply.ready),
    .distance(reply.distance),
    .overflowed(reply.overflowed)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks tree_edit_distance: streams postorder node requests and compute
// requests under random stalls, and compares every reply with a local
// Zhang-Shasha distance calculation.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ted_pkg::*;

    localparam int NODES      = 64;
    localparam int WDOG_LIMIT = 50000000;  // idle cycles tolerated (several worst computes)
    localparam int RAND_ITEMS = 750;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflowed;
    } reply_t;

    // one row of the directed table; the expected reply is typed only where obvious
    typedef struct {
        action_t             act;
        logic [LABEL_W-1:0]  lbl;
        logic [LEAF_W-1:0]   leaf;
        bit                  typed;
        int                  want_dist;
        bit                  want_ovf;
    } row_t;

    logic clk;
    logic rst_n;

    ted_req_if request ();
    ted_rsp_if reply ();

    tree_edit_distance i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .reply   (reply)
    );

    // ------------------------------------------------------------------
    // Tree store mirror and distance calculation
    // ------------------------------------------------------------------
    logic [LABEL_W-1:0] first_lbl  [NODES];
    logic [LEAF_W-1:0]  first_leaf [NODES];
    logic [LABEL_W-1:0] second_lbl [NODES];
    logic [LEAF_W-1:0]  second_leaf[NODES];
    int  first_cnt;
    int  second_cnt;
    bit  drop_seen;

    int  lm_a [NODES+1];
    int  lm_b [NODES+1];
    int  tree_tab   [NODES+1][NODES+1];
    int  forest_tab [NODES+1][NODES+1];

    reply_t pending_replies[$];
    int     errors;
    bit     idle_on;

    function automatic int min3(int a, int b, int c);
        int m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic bit is_keyroot(bit second, int n, int k);
        for (int m = k + 1; m <= n; m++)
        begin
            if (second ? (lm_b[m] == lm_b[k]) : (lm_a[m] == lm_a[k]))
                return 0;
        end
        return 1;
    endfunction

    // fill the forest table for one keyroot pair
    function automatic void fill_forest(int i, int j);
        int li, lj, rows, cols, i1, j1, dl, ins, v, ox, oy, cost;
        li   = lm_a[i];
        lj   = lm_b[j];
        rows = i - li + 1;
        cols = j - lj + 1;
        forest_tab[0][0] = 0;
        for (int x = 1; x <= rows; x++)
            forest_tab[x][0] = x;
        for (int y = 1; y <= cols; y++)
            forest_tab[0][y] = y;
        for (int x = 1; x <= rows; x++)
        begin
            i1 = li + x - 1;
            for (int y = 1; y <= cols; y++)
            begin
                j1  = lj + y - 1;
                dl  = forest_tab[x-1][y] + 1;
                ins = forest_tab[x][y-1] + 1;
                if (lm_a[i1] == li && lm_b[j1] == lj)
                begin
                    cost = (first_lbl[i1-1] == second_lbl[j1-1]) ? 0 : 1;
                    v = min3(dl, ins, forest_tab[x-1][y-1] + cost);
                    tree_tab[i1][j1] = v;
                end
                else
                begin
                    // badly nested offsets fall back to the empty forest
                    ox = (lm_a[i1] > li) ? lm_a[i1] - li : 0;
                    oy = (lm_b[j1] > lj) ? lm_b[j1] - lj : 0;
                    v = min3(dl, ins, forest_tab[ox][oy] + tree_tab[i1][j1]);
                end
                forest_tab[x][y] = v;
            end
        end
    endfunction

    function automatic int edit_distance();
        int n1, n2, d;
        n1 = first_cnt;
        n2 = second_cnt;
        if (n1 == 0)
            return n2;
        if (n2 == 0)
            return n1;
        // a leftmost leaf of 0 or past the node itself makes the node a leaf
        for (int k = 1; k <= n1; k++)
            lm_a[k] = (first_leaf[k-1] == 0 || first_leaf[k-1] > k) ? k : first_leaf[k-1];
        for (int k = 1; k <= n2; k++)
            lm_b[k] = (second_leaf[k-1] == 0 || second_leaf[k-1] > k) ? k : second_leaf[k-1];
        for (int x = 0; x <= NODES; x++)
            for (int y = 0; y <= NODES; y++)
                tree_tab[x][y] = 0;
        for (int i = 1; i <= n1; i++)
        begin
            if (!is_keyroot(0, n1, i))
                continue;
            for (int j = 1; j <= n2; j++)
            begin
                if (is_keyroot(1, n2, j))
                    fill_forest(i, j);
            end
        end
        d = tree_tab[n1][n2];
        return (d > 255) ? 255 : d;
    endfunction

    // apply one accepted request to the mirror; returns 1 when a reply follows
    function automatic bit apply_request(action_t a, logic [LABEL_W-1:0] l,
                                         logic [LEAF_W-1:0] m, output reply_t r);
        r = '0;
        case (a)
            ACT_LOAD_FIRST:
            begin
                if (first_cnt < NODES)
                begin
                    first_lbl[first_cnt]  = l;
                    first_leaf[first_cnt] = m;
                    first_cnt++;
                end
                else
                    drop_seen = 1;
            end
            ACT_LOAD_SECOND:
            begin
                if (second_cnt < NODES)
                begin
                    second_lbl[second_cnt]  = l;
                    second_leaf[second_cnt] = m;
                    second_cnt++;
                end
                else
                    drop_seen = 1;
            end
            ACT_COMPUTE:
            begin
                r.distance   = edit_distance();
                r.overflowed = drop_seen;
                first_cnt    = 0;
                second_cnt   = 0;
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // send one request; hold valid across back-to-back requests
    task automatic send_request(action_t a, logic [LABEL_W-1:0] l, logic [LEAF_W-1:0] m,
                                bit typed = 0, int want_dist = 0, bit want_ovf = 0);
        int     gap;
        reply_t r;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            request.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request.valid         <= 1'b1;
        request.action        <= a;
        request.label         <= l;
        request.leftmost_leaf <= m;
        do
            @(posedge clk);
        while (!request.ready);
        if (apply_request(a, l, m, r))
        begin
            if (typed)
            begin
                if (r.distance != want_dist)
                    report_mismatch("directed row vs calculation", r.distance, want_dist);
                r.distance   = want_dist;
                r.overflowed = want_ovf;
            end
            pending_replies.insert(pending_replies.size(), r);
        end
    endtask

    // drop valid and wait until every reply is back
    task automatic drain_replies();
        request.valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [LABEL_W-1:0] rand_label();
        // small alphabet most of the time so that renames and matches both occur
        return ($urandom_range(0, 4) == 0) ? LABEL_W'($urandom) : LABEL_W'($urandom_range(0, 3));
    endfunction

    // load one random forest in postorder; a stack holds each open subtree's leftmost leaf
    task automatic load_tree(action_t side, int n, bit noisy);
        int roots[$];
        int leaf, k;
        for (int idx = 1; idx <= n; idx++)
        begin
            if (roots.size() == 0 || $urandom_range(0, 2) == 0)
                leaf = idx;                               // new leaf
            else
            begin
                k = $urandom_range(1, roots.size());      // parent of the top k subtrees
                leaf = roots[roots.size() - k];
                repeat (k) void'(roots.pop_back());
            end
            roots.insert(roots.size(), leaf);
            if (noisy && $urandom_range(0, 7) == 0)
                leaf = $urandom_range(0, 127);
            send_request(side, rand_label(), LEAF_W'(leaf));
        end
    endtask

    function automatic int tree_size();
        int pick;
        pick = $urandom_range(0, 39);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return $urandom_range(9, NODES);
        return $urandom_range(1, 8);
    endfunction

    row_t table_rows[] = '{
        '{ACT_COMPUTE,     16'h0000, 7'd0,   1, 0, 0},   // both trees empty
        '{ACT_LOAD_FIRST,  16'h0005, 7'd1,   0, 0, 0},
        '{ACT_LOAD_FIRST,  16'h0006, 7'd2,   0, 0, 0},
        '{ACT_LOAD_FIRST,  16'h0007, 7'd1,   0, 0, 0},
        '{ACT_COMPUTE,     16'h0000, 7'd0,   1, 3, 0},   // second empty
        '{ACT_LOAD_SECOND, 16'h0000, 7'd1,   0, 0, 0},
        '{ACT_LOAD_SECOND, 16'hFFFF, 7'd0,   0, 0, 0},   // zero leftmost leaf
        '{ACT_COMPUTE,     16'h0000, 7'd0,   1, 2, 0},   // first empty
        '{ACT_LOAD_FIRST,  16'hFFFF, 7'd1,   0, 0, 0},
        '{ACT_LOAD_SECOND, 16'hFFFF, 7'd1,   0, 0, 0},
        '{ACT_COMPUTE,     16'h0000, 7'd0,   1, 0, 0},   // identical single nodes
        '{ACT_LOAD_FIRST,  16'h0000, 7'd1,   0, 0, 0},
        '{ACT_LOAD_SECOND, 16'hFFFF, 7'd127, 0, 0, 0},   // leftmost leaf past itself
        '{ACT_NOP,         16'hFFFF, 7'd127, 0, 0, 0},   // unused action
        '{ACT_COMPUTE,     16'h0000, 7'd0,   1, 1, 0},   // one rename
        '{ACT_LOAD_FIRST,  16'h000A, 7'd1,   0, 0, 0},
        '{ACT_LOAD_FIRST,  16'h000B, 7'd2,   0, 0, 0},
        '{ACT_LOAD_FIRST,  16'h000C, 7'd1,   0, 0, 0},
        '{ACT_LOAD_SECOND, 16'h000A, 7'd1,   0, 0, 0},
        '{ACT_LOAD_SECOND, 16'h000C, 7'd1,   0, 0, 0},
        '{ACT_COMPUTE,     16'h0000, 7'd0,   0, 0, 0},   // one delete
        '{ACT_LOAD_FIRST,  16'h0001, 7'd1,   0, 0, 0},
        '{ACT_LOAD_FIRST,  16'h0002, 7'd2,   0, 0, 0},
        '{ACT_LOAD_FIRST,  16'h0003, 7'd1,   0, 0, 0},
        '{ACT_LOAD_FIRST,  16'h0004, 7'd3,   0, 0, 0},   // badly nested leaf
        '{ACT_LOAD_SECOND, 16'h0004, 7'd1,   0, 0, 0},
        '{ACT_LOAD_SECOND, 16'h0001, 7'd1,   0, 0, 0},
        '{ACT_COMPUTE,     16'h0000, 7'd0,   0, 0, 0}
    };

    initial
    begin
        int items;
        errors     = 0;
        first_cnt  = 0;
        second_cnt = 0;
        drop_seen  = 0;
        idle_on    = 1;
        request.valid         <= 1'b0;
        request.action        <= ACT_NOP;
        request.label         <= '0;
        request.leftmost_leaf <= '0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        foreach (table_rows[r])
            send_request(table_rows[r].act, table_rows[r].lbl, table_rows[r].leaf,
                         table_rows[r].typed, table_rows[r].want_dist, table_rows[r].want_ovf);

        // hold off until every reply of the directed part is back
        drain_replies();

        items = 0;
        while (items < RAND_ITEMS)
        begin
            int n1, n2;
            bit noisy;
            // drop stalls for the last stretch of the run
            if (items > RAND_ITEMS - 150)
                idle_on = 0;
            if (items > 450 && !drop_seen)
            begin
                // overfill both trees with leaves, then compute with the sticky flag up
                drain_replies();
                for (int k = 1; k <= NODES + 1; k++)
                    send_request(ACT_LOAD_FIRST, rand_label(), LEAF_W'(k));
                for (int k = 1; k <= NODES + 2; k++)
                    send_request(ACT_LOAD_SECOND, rand_label(), LEAF_W'(k));
                send_request(ACT_COMPUTE, '0, '0);
                items += 2 * NODES + 4;
                continue;
            end
            noisy = ($urandom_range(0, 4) == 0);
            n1 = tree_size();
            n2 = tree_size();
            load_tree(ACT_LOAD_FIRST, n1, noisy);
            load_tree(ACT_LOAD_SECOND, n2, noisy);
            if ($urandom_range(0, 9) == 0)
                send_request(ACT_NOP, LABEL_W'($urandom), LEAF_W'($urandom));
            send_request(ACT_COMPUTE, LABEL_W'($urandom), LEAF_W'($urandom));
            items += n1 + n2 + 1;
        end

        drain_replies();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tree_edit_distance verification clean");
        else
            $display("tree_edit_distance verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Reply side: random backpressure and checking
    // ------------------------------------------------------------------
    initial
    begin
        reply.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                reply.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            reply.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && reply.valid && reply.ready)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("reply with none pending", reply.distance, -1);
            else
            begin
                want = pending_replies.pop_front();
                if (reply.distance !== want.distance)
                    report_mismatch("distance", reply.distance, want.distance);
                if (reply.overflowed !== want.overflowed)
                    report_mismatch("overflowed", reply.overflowed, want.overflowed);
            end
        end
    end

    // watchdog: end the run if nothing moves on either channel for too long
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((request.valid && request.ready) || (reply.valid && reply.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("tree_edit_distance verification failed");
            $finish;
        end
    end

endmodule
